FILE: design/ptn_pkg.sv
package ptn_pkg;

    localparam int BUFFER_DEPTH_DEF = 512;
    localparam int KEEP_LIMIT_DEF   = 64;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [6:0] CFG_CAP_RESET = 7'd65;

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_DOT   = 7'h2E;
    localparam logic [6:0] CHAR_COMMA = 7'h2C;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       is_last;
        logic       is_empty;
        logic [6:0] out_length;
    } out_item_t;

    // classified request between front and back
    typedef struct packed {
        logic       is_end;
        logic [6:0] ch;
    } q_item_t;

endpackage

FILE: design/prompt_text_normalizer_unit.sv
// Prompt text normalizer.
// Input side is a queue: drive in_item and raise push; the request is taken on a
// clock edge where full is low. A character request (kind 0) is lowercased,
// filtered and stored; an end request (kind 1) closes the string.
// Result side is a queue too: while empty is low, out_item holds the oldest
// result; raise pop to take it. is_last marks the final result of a string.
// Throughput: one character request per cycle while the sequencer is idle, set by
// the single write port of the character buffer. A four-entry queue separates
// intake from the buffer sequencer, so characters keep flowing into it while a
// string is processed, until the queue is full. End request: the sequencer takes
// it from the queue, strips trailing spaces, dots and commas (a buffer read and a
// check per character), sets the window, skips leading spaces (a read and a check
// per space and for the first kept character), computes the length, then emits
// each character (buffer read, output register load). An empty buffer gives its
// single result.
// A stalled receiver holds the sequencer at the output register; the input
// queue then fills and full rises. Reset empties the queue and output register,
// clears the string and sets output_capacity to 65; the buffer is not cleared.
// cfg_wr_en with cfg_wr_data writes output_capacity; write it only when idle.
module prompt_text_normalizer_unit
    import ptn_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int KEEP_LIMIT   = KEEP_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   in_item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  out_item,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data
);

    logic    q_full;
    logic    q_push;
    q_item_t q_in;
    logic    q_valid;
    logic    q_pop;
    q_item_t q_out;

    ptn_front u_front (
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in)
    );

    ptn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .pop_item  (q_out)
    );

    ptn_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .KEEP_LIMIT   (KEEP_LIMIT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_out),
        .q_pop       (q_pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item)
    );

endmodule

FILE: design/ptn_front.sv
module ptn_front
    import ptn_pkg::*;
(
    input  logic     push,
    output logic     full,
    input  in_item_t in_item,
    input  logic     q_full,
    output logic     q_push,
    output q_item_t  q_item
);

    function automatic logic [6:0] classify(input logic [7:0] c);
        logic [7:0] lc;
        logic       ok;
        lc = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            lc = c + 8'h20;
        end
        ok = 1'b0;
        if (lc >= 8'h61 && lc <= 8'h7A)
        begin
            ok = 1'b1;
        end
        if (lc >= 8'h30 && lc <= 8'h39)
        begin
            ok = 1'b1;
        end
        case (lc)
            8'h20, 8'h27, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h2E,
            8'h2C, 8'h25, 8'h5E, 8'h28, 8'h29, 8'h3D: ok = 1'b1;
            default: ;
        endcase
        return ok ? lc[6:0] : CHAR_SPACE;
    endfunction

    assign full          = q_full;
    assign q_push        = push && !q_full;
    assign q_item.is_end = in_item.kind;
    assign q_item.ch     = classify(in_item.char_code);

endmodule

FILE: design/ptn_queue.sv
module ptn_queue
    import ptn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    output logic    valid,
    input  logic    pop,
    output q_item_t pop_item
);

    q_item_t          entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/ptn_back.sv
module ptn_back
    import ptn_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int KEEP_LIMIT   = KEEP_LIMIT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  q_item_t   q_item,
    output logic      q_pop,
    input  logic      cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    localparam int CNT_W  = $clog2(BUFFER_DEPTH);
    localparam int WIDE_W = (CNT_W > 7 ? CNT_W : 7) + 1;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_STRIP_RD  = 8'b0000_0010,
        S_STRIP_CHK = 8'b0000_0100,
        S_WIN       = 8'b0000_1000,
        S_SKIP_RD   = 8'b0001_0000,
        S_SKIP_CHK  = 8'b0010_0000,
        S_LEN       = 8'b0100_0000,
        S_EMIT      = 8'b1000_0000
    } state_t;

    logic [6:0]       mem [BUFFER_DEPTH];
    logic [6:0]       rd_data_reg;
    logic             rd_en;
    logic [CNT_W-1:0] rd_addr;
    logic             wr_en;

    state_t           state_reg,   state_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic             lws_reg,     lws_next;
    logic [CNT_W-1:0] n_reg,       n_next;
    logic [CNT_W-1:0] start_reg,   start_next;
    logic [6:0]       rem_reg,     rem_next;
    logic [6:0]       len_reg,     len_next;
    logic             wait_rd_reg, wait_rd_next;
    logic [6:0]       cap_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg,     out_next;

    logic             slot_free;
    logic [WIDE_W-1:0] n_wide;
    logic [WIDE_W-1:0] win_start;
    logic [WIDE_W-1:0] len_wide;
    logic [WIDE_W-1:0] lim_wide;
    logic [WIDE_W-1:0] clip_wide;
    logic [6:0]       cap_eff;
    logic             is_strip;

    assign empty     = !out_valid_reg;
    assign out_item  = out_reg;
    assign slot_free = !out_valid_reg || pop;

    assign n_wide    = WIDE_W'(n_reg);
    assign win_start = (n_wide > WIDE_W'(KEEP_LIMIT)) ? n_wide - WIDE_W'(KEEP_LIMIT) : '0;
    assign len_wide  = WIDE_W'(n_reg - start_reg);
    assign cap_eff   = (cap_reg == 7'd0) ? 7'd1 : cap_reg;
    assign lim_wide  = WIDE_W'(cap_eff) - 1'b1;
    assign clip_wide = (len_wide > lim_wide) ? lim_wide : len_wide;
    assign is_strip  = (rd_data_reg == CHAR_SPACE) || (rd_data_reg == CHAR_DOT) ||
                       (rd_data_reg == CHAR_COMMA);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg] <= q_item.ch;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lws_next       = lws_reg;
        n_next         = n_reg;
        start_next     = start_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        wait_rd_next   = wait_rd_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = start_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.is_end)
                    begin
                        n_next     = count_reg;
                        state_next = S_STRIP_RD;
                    end
                    else if (count_reg < CNT_W'(BUFFER_DEPTH - 1))
                    begin
                        // drop a space that follows a space or opens the string
                        if (!(q_item.ch == CHAR_SPACE && lws_reg))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                            lws_next   = (q_item.ch == CHAR_SPACE);
                        end
                    end
                end
            end
            S_STRIP_RD:
            begin
                if (n_reg == '0)
                begin
                    state_next = S_WIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = n_reg - 1'b1;
                    state_next = S_STRIP_CHK;
                end
            end
            S_STRIP_CHK:
            begin
                if (is_strip)
                begin
                    n_next     = n_reg - 1'b1;
                    state_next = S_STRIP_RD;
                end
                else
                begin
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                start_next = win_start[CNT_W-1:0];
                state_next = S_SKIP_RD;
            end
            S_SKIP_RD:
            begin
                if (start_reg < n_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_SKIP_CHK;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_SKIP_CHK:
            begin
                if (rd_data_reg == CHAR_SPACE)
                begin
                    start_next = start_reg + 1'b1;
                    state_next = S_SKIP_RD;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                len_next     = clip_wide[6:0];
                rem_next     = clip_wide[6:0];
                wait_rd_next = 1'b0;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (rem_reg == 7'd0)
                begin
                    // empty string: one marker result
                    if (slot_free)
                    begin
                        out_valid_next      = 1'b1;
                        out_next.out_char   = 7'd0;
                        out_next.is_last    = 1'b1;
                        out_next.is_empty   = 1'b1;
                        out_next.out_length = 7'd0;
                        count_next          = '0;
                        lws_next            = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                else if (!wait_rd_reg)
                begin
                    rd_en        = 1'b1;
                    start_next   = start_reg + 1'b1;
                    wait_rd_next = 1'b1;
                end
                else if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.out_char   = rd_data_reg;
                    out_next.is_last    = (rem_reg == 7'd1);
                    out_next.is_empty   = 1'b0;
                    out_next.out_length = len_reg;
                    rem_next            = rem_reg - 1'b1;
                    wait_rd_next        = 1'b0;
                    if (rem_reg == 7'd1)
                    begin
                        count_next = '0;
                        lws_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        start_reg <= start_next;
        rem_reg   <= rem_next;
        len_reg   <= len_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lws_reg       <= 1'b1;
            wait_rd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CFG_CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lws_reg       <= lws_next;
            wait_rd_reg   <= wait_rd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

endmodule

FILE: tb/sv/prompt_text_normalizer_unit_tb.sv
`timescale 1ns / 1ps

module prompt_text_normalizer_unit_tb;
    import ptn_pkg::*;

    localparam int BUF_DEPTH     = BUFFER_DEPTH_DEF;
    localparam int KEEP_CHARS    = KEEP_LIMIT_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_STALL    = 400;
    localparam int IDLE_LIMIT    = 4000;
    localparam int PRINT_LIMIT   = 40;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // punctuation that survives the filter
    localparam logic [8*13-1:0] PUNCT_SET = {8'h20, 8'h27, 8'h2B, 8'h2D, 8'h2A, 8'h2F,
                                             8'h2E, 8'h2C, 8'h25, 8'h5E, 8'h28, 8'h29,
                                             8'h3D};

    // leading spaces, case extremes, digits, zero and high bytes, punctuation, trailing
    localparam logic [8*24-1:0] DIRECTED_TEXT = {8'h20, 8'h20, 8'h41, 8'h5A, 8'h61, 8'h7A,
                                                 8'h30, 8'h39, 8'h00, 8'hFF, 8'h2B, 8'h2D,
                                                 8'h2A, 8'h2F, 8'h25, 8'h5E, 8'h28, 8'h29,
                                                 8'h3D, 8'h27, 8'h80, 8'h2E, 8'h2C, 8'h20};

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    in_item_t   in_item     = '0;
    logic       empty;
    logic       pop         = 1'b0;
    out_item_t  out_item;
    logic       cfg_wr_en   = 1'b0;
    logic [6:0] cfg_wr_data = 7'd0;

    // predictor state
    logic [6:0]  text_buf [0:BUF_DEPTH-1];
    int unsigned text_len   = 0;
    bit          last_blank = 1'b1;
    logic [6:0]  out_cap    = CFG_CAP_RESET;

    in_item_t  request_q [$];
    out_item_t norm_q [$];
    out_item_t head_item;

    int unsigned err_count   = 0;
    int unsigned send_gap    = 0;
    int unsigned rcv_gap     = 0;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;
    bit          quiet       = 1'b0;
    bit          stall_req   = 1'b0;
    bit          stall_done  = 1'b0;

    prompt_text_normalizer_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(string msg);
        if (err_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [6:0] fold_char(logic [7:0] b);
        logic [7:0] c;
        bit         ok;
        c = b;
        if (c >= 8'h41 && c <= 8'h5A)
            c = c + 8'h20;
        ok = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39);
        for (int i = 0; i < 13; i++)
            if (PUNCT_SET[8*i +: 8] == c)
                ok = 1'b1;
        return ok ? c[6:0] : CHAR_SPACE;
    endfunction

    function automatic void normalize_request(in_item_t req);
        logic [6:0]  ch;
        int unsigned stop;
        int unsigned first;
        int unsigned n;
        int unsigned lim;
        if (req.kind == KIND_CHAR)
        begin
            // drop bytes once the buffer is full
            if (text_len >= BUF_DEPTH - 1)
                return;
            ch = fold_char(req.char_code);
            if (ch == CHAR_SPACE)
            begin
                if (last_blank)
                    return;
                last_blank = 1'b1;
            end
            else
            begin
                last_blank = 1'b0;
            end
            text_buf[text_len] = ch;
            text_len++;
            return;
        end
        stop = text_len;
        while (stop > 0 && (text_buf[stop-1] == CHAR_SPACE || text_buf[stop-1] == CHAR_DOT
                            || text_buf[stop-1] == CHAR_COMMA))
            stop--;
        first = (stop > KEEP_CHARS) ? stop - KEEP_CHARS : 0;
        while (first < stop && text_buf[first] == CHAR_SPACE)
            first++;
        n = stop - first;
        lim = (out_cap == 0) ? 1 : out_cap;
        if (n > lim - 1)
            n = lim - 1;
        if (n == 0)
        begin
            norm_q.push_back(out_item_t'{7'd0, 1'b1, 1'b1, 7'd0});
        end
        else
        begin
            for (int unsigned k = 0; k < n; k++)
                norm_q.push_back(out_item_t'{text_buf[first+k], (k + 1 == n), 1'b0, 7'(n)});
        end
        text_len = 0;
        last_blank = 1'b1;
    endfunction

    function automatic logic [7:0] random_byte();
        int unsigned k;
        k = $urandom_range(0, 12);
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
            3:       return 8'h41 + 8'($urandom_range(0, 25));
            4:       return 8'h30 + 8'($urandom_range(0, 9));
            5:       return PUNCT_SET[8*k +: 8];
            6:       return {1'b0, CHAR_SPACE};
            7:       return $urandom_range(0, 1) ? {1'b0, CHAR_DOT} : {1'b0, CHAR_COMMA};
            8:       return 8'($urandom_range(0, 255));
            default: return $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(128, 255));
        endcase
    endfunction

    // dense strings are mostly letters so that they overrun the keep window
    function automatic void queue_string(int unsigned n, bit dense);
        logic [7:0] b;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (dense && $urandom_range(0, 7) != 0)
                b = 8'h61 + 8'($urandom_range(0, 25));
            else
                b = random_byte();
            request_q.push_back(in_item_t'{KIND_CHAR, b});
        end
        request_q.push_back(in_item_t'{KIND_END, 8'($urandom_range(0, 255))});
    endfunction

    task automatic drain_and_settle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || push || norm_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(logic [6:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        out_cap = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                normalize_request(in_item);
            if (!push || !full)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    in_item <= request_q.pop_front();
                    push    <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 16);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (norm_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, char %0h", out_item.out_char));
                end
                else
                begin
                    head_item = norm_q.pop_front();
                    if (out_item.out_char !== head_item.out_char)
                        report_mismatch($sformatf("out_char got %0h want %0h",
                                                  out_item.out_char, head_item.out_char));
                    if (out_item.is_last !== head_item.is_last)
                        report_mismatch($sformatf("is_last got %0b want %0b",
                                                  out_item.is_last, head_item.is_last));
                    if (out_item.is_empty !== head_item.is_empty)
                        report_mismatch($sformatf("is_empty got %0b want %0b",
                                                  out_item.is_empty, head_item.is_empty));
                    if (out_item.out_length !== head_item.out_length)
                        report_mismatch($sformatf("out_length got %0d want %0d",
                                                  out_item.out_length, head_item.out_length));
                end
            end
            if (stall_req && !stall_done)
            begin
                stall_left = LONG_STALL;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (rcv_gap > 0)
            begin
                rcv_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    rcv_gap = $urandom_range(1, 16);
            end
        end
    end

    // watchdog: no request or result moving for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed strings at the reset capacity
        @(negedge clk);
        request_q.push_back(in_item_t'{KIND_END, 8'h00});
        for (int i = 23; i >= 0; i--)
            request_q.push_back(in_item_t'{KIND_CHAR, DIRECTED_TEXT[8*i +: 8]});
        request_q.push_back(in_item_t'{KIND_END, 8'hFF});
        drain_and_settle();

        @(negedge clk);
        for (int i = 0; i < 5; i++)
            queue_string($urandom_range(0, 12), 1'b0);
        // hold the sender until every result is back
        drain_and_settle();
        @(negedge clk);
        for (int i = 0; i < 3; i++)
            queue_string($urandom_range(0, 12), 1'b0);
        drain_and_settle();

        set_capacity(7'd1);
        @(negedge clk);
        for (int i = 0; i < 3; i++)
            queue_string($urandom_range(0, 10), 1'b0);
        drain_and_settle();

        set_capacity(7'd0);
        @(negedge clk);
        for (int i = 0; i < 3; i++)
            queue_string($urandom_range(0, 10), 1'b0);
        drain_and_settle();

        // receiver holds off while a string longer than the keep window is offered
        set_capacity(7'd127);
        @(negedge clk);
        stall_req = 1'b1;
        queue_string(70, 1'b1);
        for (int i = 0; i < 2; i++)
            queue_string($urandom_range(4, 10), 1'b0);
        drain_and_settle();

        set_capacity(7'd2);
        @(negedge clk);
        for (int i = 0; i < 3; i++)
            queue_string($urandom_range(0, 10), 1'b0);
        drain_and_settle();

        set_capacity(7'($urandom_range(3, 64)));
        @(negedge clk);
        for (int i = 0; i < 3; i++)
            queue_string($urandom_range(0, 14), 1'b0);
        drain_and_settle();

        // final stretch without idling
        set_capacity(CFG_CAP_RESET);
        @(negedge clk);
        quiet = 1'b1;
        for (int i = 0; i < 3; i++)
            queue_string($urandom_range(0, 12), 1'b0);
        drain_and_settle();

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
